>>> hdl/nca_pkg.sv
`default_nettype none
package nca_pkg;

  localparam int NUM_CENTROIDS_DEF = 8;
  localparam int VECTOR_DIM_DEF    = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam int VAL_W  = 16;
  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int DIST_W = 38;
  localparam int MAG_W  = VAL_W;
  localparam int SQ_W   = 2 * MAG_W;

  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  ACTIVE_RST  = 7'd8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        centroid_index;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] value;
    logic                    last_element;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_centroid;
    logic [DIST_W-1:0] nearest_distance;
  } out_item_t;

  // classified item held between front and back
  typedef struct packed {
    logic                    is_data;
    logic                    in_range;
    logic                    last;
    logic [IDX_W-1:0]        cidx;
    logic [IDX_W-1:0]        eidx;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // control fanned out to every distance cell
  typedef struct packed {
    logic                    load;
    logic [IDX_W-1:0]        cidx;
    logic [IDX_W-1:0]        addr;
    logic signed [VAL_W-1:0] wdata;
    logic signed [VAL_W-1:0] s1_value;
    logic                    add;
    logic                    clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/nearest_centroid_assign.sv
// nearest_centroid_assign: streaming k-means assignment step.
// Input channel (in_push / in_full, in_item): each transfer either loads one
// centroid element into the per-centroid banks or delivers one element of a
// data vector. A data element marked last_element yields one result.
// Result channel (out_empty / out_pop, out_item): index of the nearest active
// centroid (lowest index on ties) and its squared distance, 38 bits saturated.
// Configuration: cfg_we / cfg_data write active_centroids (reset 8, zero acts
// as 1, values above NUM_CENTROIDS clamp to it); write it only while idle.
// Throughput: one element per cycle while in_full is low, one distance cell per centroid.
// A last element passes the queue, bank read, difference, square and
// accumulate steps, then a minimum search of one centroid per cycle, before
// its result reaches the result port.
// A last element waits at the queue head while an earlier one is in flight
// or its search runs, so short vectors lower the rate.
// When out_pop stays low the finished result holds and the search stalls;
// the 4-entry queue then fills and in_full rises.
// Reset clears queue, accumulators, result and the register; centroid banks
// hold no reset value and must be loaded before use.
`default_nettype none
module nearest_centroid_assign #(
  parameter int NUM_CENTROIDS = nca_pkg::NUM_CENTROIDS_DEF,
  parameter int VECTOR_DIM    = nca_pkg::VECTOR_DIM_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire nca_pkg::in_item_t          in_item,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output nca_pkg::out_item_t              out_item,
  input  wire logic                       cfg_we,
  input  wire logic [nca_pkg::CNT_W-1:0]  cfg_data
);

  logic                       head_valid;
  nca_pkg::cmd_t              head;
  logic                       issue;
  logic                       head_last;
  logic                       scan_busy;
  logic [nca_pkg::CNT_W-1:0]  active_r;
  logic [nca_pkg::CNT_W-1:0]  active_n;
  nca_pkg::cell_ctl_t         ctl;
  logic [NUM_CENTROIDS-1:0][nca_pkg::DIST_W-1:0] snap;

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_inr_r, s2_inr_r, s3_inr_r;
  logic s1_last_r, s2_last_r, s3_last_r;
  logic signed [nca_pkg::VAL_W-1:0] s1_value_r;

  nca_front #(
    .NUM_CENTROIDS(NUM_CENTROIDS),
    .VECTOR_DIM   (VECTOR_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .head_valid(head_valid),
    .head      (head),
    .head_pop  (issue)
  );

  // only one vector end may be in flight or under search at a time
  assign head_last = head.is_data && head.last;
  assign issue     = head_valid &&
                     !(head_last && (s1_last_r || s2_last_r || s3_last_r || scan_busy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= nca_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      active_r <= cfg_data;
    end
  end

  always_comb begin
    if (active_r == '0) begin
      active_n = nca_pkg::CNT_W'(1);
    end else if (active_r > nca_pkg::CNT_W'(NUM_CENTROIDS)) begin
      active_n = nca_pkg::CNT_W'(NUM_CENTROIDS);
    end else begin
      active_n = active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s1_inr_r  <= 1'b0;
      s2_inr_r  <= 1'b0;
      s3_inr_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_last_r <= 1'b0;
      s3_last_r <= 1'b0;
    end else begin
      s1_v_r    <= issue && head.is_data;
      s1_inr_r  <= issue && head.is_data && head.in_range;
      s1_last_r <= issue && head_last;
      s2_v_r    <= s1_v_r;
      s2_inr_r  <= s1_inr_r;
      s2_last_r <= s1_last_r;
      s3_v_r    <= s2_v_r;
      s3_inr_r  <= s2_inr_r;
      s3_last_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_value_r <= head.value;
  end

  always_comb begin
    ctl.load     = issue && !head.is_data;
    ctl.cidx     = head.cidx;
    ctl.addr     = head.eidx;
    ctl.wdata    = head.value;
    ctl.s1_value = s1_value_r;
    ctl.add      = s3_v_r && s3_inr_r;
    ctl.clear    = s3_v_r && s3_last_r;
  end

  for (genvar c = 0; c < NUM_CENTROIDS; c++) begin : g_cell
    nca_cell #(
      .VECTOR_DIM(VECTOR_DIM),
      .CELL_ID   (c)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .snap (snap[c])
    );
  end

  nca_scan #(
    .NUM_CENTROIDS(NUM_CENTROIDS)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.clear),
    .active_n (active_n),
    .snap     (snap),
    .busy     (scan_busy),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

>>> hdl/nca_ram.sv
`default_nettype none
module nca_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> hdl/nca_front.sv
`default_nettype none
module nca_front #(
  parameter int NUM_CENTROIDS = nca_pkg::NUM_CENTROIDS_DEF,
  parameter int VECTOR_DIM    = nca_pkg::VECTOR_DIM_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire nca_pkg::in_item_t in_item,
  output logic                  head_valid,
  output nca_pkg::cmd_t         head,
  input  wire logic             head_pop
);

  localparam int PTR_W = $clog2(nca_pkg::QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(nca_pkg::QUEUE_DEPTH + 1);

  nca_pkg::cmd_t     q_r [nca_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_Q-1:0]  count_r;
  nca_pkg::cmd_t     cmd;
  logic              load_ok;
  logic              keep;
  logic              do_push;
  logic              do_pop;

  assign in_full    = (count_r == CNT_Q'(nca_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];

  // out-of-range loads are dropped here, data elements always go through
  always_comb begin
    load_ok = (nca_pkg::CNT_W'(in_item.centroid_index) < nca_pkg::CNT_W'(NUM_CENTROIDS)) &&
              (7'(in_item.element_index) < 7'(VECTOR_DIM));
    cmd.is_data  = (in_item.operation == nca_pkg::OP_DATA);
    cmd.in_range = (7'(in_item.element_index) < 7'(VECTOR_DIM));
    cmd.last     = cmd.is_data && in_item.last_element;
    cmd.cidx     = in_item.centroid_index;
    cmd.eidx     = in_item.element_index;
    cmd.value    = in_item.value;
    keep         = cmd.is_data || load_ok;
  end

  assign do_push = in_push && !in_full && keep;
  assign do_pop  = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule
`default_nettype wire

>>> hdl/nca_cell.sv
`default_nettype none
module nca_cell #(
  parameter int VECTOR_DIM = nca_pkg::VECTOR_DIM_DEF,
  parameter int CELL_ID    = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire nca_pkg::cell_ctl_t           ctl,
  output logic [nca_pkg::DIST_W-1:0]        snap
);

  localparam int AW = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;

  logic [nca_pkg::VAL_W-1:0]  rd_data;
  logic                       we;
  logic signed [nca_pkg::VAL_W:0] diff;
  logic [nca_pkg::MAG_W-1:0]  mag_r;
  logic [nca_pkg::SQ_W-1:0]   sq_r;
  logic [nca_pkg::DIST_W-1:0] acc_r;
  logic [nca_pkg::DIST_W:0]   sum;
  logic [nca_pkg::DIST_W-1:0] acc_sat;

  assign we = ctl.load && (ctl.cidx == nca_pkg::IDX_W'(CELL_ID));

  nca_ram #(
    .WIDTH (nca_pkg::VAL_W),
    .DEPTH (VECTOR_DIM),
    .ADDR_W(AW)
  ) u_bank (
    .clk  (clk),
    .we   (we),
    .addr (ctl.addr[AW-1:0]),
    .wdata(ctl.wdata),
    .rdata(rd_data)
  );

  assign diff = (nca_pkg::VAL_W+1)'(ctl.s1_value) -
                (nca_pkg::VAL_W+1)'($signed(rd_data));

  always_ff @(posedge clk) begin
    mag_r <= diff[nca_pkg::VAL_W] ? nca_pkg::MAG_W'(-diff) : nca_pkg::MAG_W'(diff);
    sq_r  <= mag_r * mag_r;
  end

  assign sum     = {1'b0, acc_r} + (nca_pkg::DIST_W+1)'(sq_r);
  assign acc_sat = sum[nca_pkg::DIST_W] ? nca_pkg::DIST_MAX : sum[nca_pkg::DIST_W-1:0];
  // value including the element now in the last stage
  assign snap    = ctl.add ? acc_sat : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.add) begin
      acc_r <= acc_sat;
    end
  end

endmodule
`default_nettype wire

>>> hdl/nca_scan.sv
`default_nettype none
module nca_scan #(
  parameter int NUM_CENTROIDS = nca_pkg::NUM_CENTROIDS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        start,
  input  wire logic [nca_pkg::CNT_W-1:0]                   active_n,
  input  wire logic [NUM_CENTROIDS-1:0][nca_pkg::DIST_W-1:0] snap,
  output logic                                             busy,
  output logic                                             out_empty,
  input  wire logic                                        out_pop,
  output nca_pkg::out_item_t                               out_item
);

  logic [nca_pkg::DIST_W-1:0] line_r [NUM_CENTROIDS];
  logic [nca_pkg::CNT_W-1:0]  idx_r;
  logic [nca_pkg::CNT_W-1:0]  n_r;
  logic [nca_pkg::DIST_W-1:0] best_r;
  logic [nca_pkg::IDX_W-1:0]  best_idx_r;
  logic                       busy_r;
  logic                       out_valid_r;
  nca_pkg::out_item_t         out_r;
  logic                       stepping;
  logic                       finish;
  logic                       taken;

  assign busy      = busy_r;
  assign out_empty = !out_valid_r;
  assign out_item  = out_r;
  assign taken     = out_valid_r && out_pop;
  assign stepping  = busy_r && (idx_r < n_r);
  assign finish    = busy_r && (idx_r >= n_r) && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= nca_pkg::CNT_W'(1);
        n_r    <= active_n;
      end else if (stepping) begin
        idx_r <= idx_r + 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      // a finish in the cycle of a transfer refills the slot
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (start) begin
      best_r     <= snap[0];
      best_idx_r <= '0;
    end else if (stepping && (line_r[0] < best_r)) begin
      best_r     <= line_r[0];
      best_idx_r <= idx_r[nca_pkg::IDX_W-1:0];
    end
    if (finish) begin
      out_r.nearest_centroid <= best_idx_r;
      out_r.nearest_distance <= best_r;
    end
  end

  // shift line: head entry is the centroid under compare
  for (genvar k = 0; k < NUM_CENTROIDS; k++) begin : g_line
    if (k < NUM_CENTROIDS - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (start) begin
          line_r[k] <= snap[k+1];
        end else if (stepping) begin
          line_r[k] <= line_r[k+1];
        end
      end
    end else begin : g_end
      always_ff @(posedge clk) begin
        if (start || stepping) begin
          line_r[k] <= '0;
        end
      end
    end
  end

endmodule
`default_nettype wire
